### rtl/core/pfq_pkg.sv
// Shared types, codes and constants of the strict-priority frame queue.
// Used by pfq_ctrl, pfq_dpath and priority_frame_queue_lifetime_discard.
package pfq_pkg;

  localparam int EntriesPerPrio = 64;
  localparam int PrioLevels     = 3;

  localparam logic [1:0] OP_ENQ   = 2'd0;
  localparam logic [1:0] OP_DEQ   = 2'd1;
  localparam logic [1:0] OP_PREP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] PRIO_MGMT  = 2'd0;
  localparam logic [1:0] PRIO_SIG   = 2'd1;
  localparam logic [1:0] PRIO_OTHER = 2'd2;
  localparam logic [1:0] PRIO_NONE  = 2'd3;

  localparam logic [0:0] REG_HYST   = 1'd0;
  localparam logic [0:0] REG_FORCED = 1'd1;

  localparam logic [15:0] LIFE_INFINITE = 16'hffff;
  localparam logic [10:0] DISCARD_MIN   = 11'd60;
  localparam logic [7:0]  TYPE_MASK     = 8'he0;
  localparam logic [7:0]  TYPE_UI       = 8'hc0;
  localparam logic [7:0]  FRAMES_MAX    = 8'hff;
  localparam logic [23:0] OCTETS_MAX    = 24'hffffff;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [15:0] frame_tag;
    logic [10:0] frame_length;
    logic [7:0]  first_octet;
    logic [15:0] lifetime_csec;
    logic [1:0]  put_back_prio;
    logic [31:0] put_back_recv_ms;
    logic [31:0] put_back_expire_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  frame_prio;
    logic [15:0] out_tag;
    logic [10:0] out_length;
    logic [31:0] out_recv_ms;
    logic [31:0] out_expire_ms;
    logic [7:0]  dropped_frames;
    logic [23:0] dropped_octets;
    logic [7:0]  queued_frames;
    logic [18:0] queued_octets;
    logic [31:0] avg_delay_ms;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic dq_init;
    logic dq_pop;
    logic dq_empty;
    logic dq_eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_deq;
    logic any_queued;
    logic keep;
    logic out_free;
  } stat_t;

  function automatic logic [1:0] sapi_prio(input logic [7:0] octet);
    logic [3:0] s;
    s = octet[3:0];
    if (s == 4'd1) return PRIO_MGMT;
    if (s == 4'd2 || s == 4'd7 || s == 4'd8) return PRIO_SIG;
    return PRIO_OTHER;
  endfunction

  function automatic logic can_discard(input logic [10:0] len, input logic [7:0] octet);
    return (len > DISCARD_MIN) && (octet[3:0] != 4'd1) && ((octet & TYPE_MASK) == TYPE_UI);
  endfunction

endpackage

### rtl/core/priority_frame_queue_lifetime_discard.sv
// Top level of the strict-priority frame queue with lifetime discard.
// Instantiates pfq_ctrl and pfq_dpath; types and codes come from pfq_pkg.
// Usage:
//   req channel (req_valid/req_ready/req) carries one command word: enqueue,
//   dequeue, prepend or clear. rsp channel (rsp_valid/rsp_ready/rsp) returns
//   exactly one result word per command, in command order.
//   cfg channel writes the hysteresis margin (index 0) and the forced lifetime
//   (index 1); it is always ready and should be written only while idle.
// Steps:
//   Enqueue, prepend and clear go through accept, execute and result load.
//   Dequeue goes through accept and init, then for each head examined a memory
//   read and an evaluate step on the single read port of the descriptor
//   memory, then result load; when no frame is left, a pick step that finds
//   the rings empty comes before result load. One command is in flight.
// Reset: rings, totals, average delay and both registers go to zero; the
//   descriptor memory is not cleared (unwritten slots are never read).
// Stall: a finished result waits in the output register while req_ready is
//   already high again; the next result holds until the register frees.
module priority_frame_queue_lifetime_discard #(
  parameter int ENTRIES_PER_PRIO = pfq_pkg::EntriesPerPrio
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pfq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pfq_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [0:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  pfq_pkg::cmd_t  cmd;
  pfq_pkg::stat_t stat;

  // config writes land at once
  assign cfg_ready = 1'b1;

  pfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfq_dpath #(
    .ENTRIES_PER_PRIO (ENTRIES_PER_PRIO)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef SYNTH
  // one command at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a second command while busy");

  // empty or rejected results carry no descriptor
  a_no_desc_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != pfq_pkg::ST_OK |-> rsp.out_tag == '0 && rsp.out_length == '0)
    else $error("descriptor on failed result");

  // dropped octets only come with dropped frames
  a_drop_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dropped_frames == '0 |-> rsp.dropped_octets == '0)
    else $error("octets dropped without frames");
`endif

endmodule

### rtl/core/pfq_ctrl.sv
// Sequencer of the frame queue: steps each command through its datapath cycles.
// Depends on pfq_pkg for the command and status structs.
module pfq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pfq_pkg::stat_t stat,
  output pfq_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PICK, S_EVAL, S_DONE} state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_deq) begin
          cmd.dq_init = 1'b1;
          state_next  = S_PICK;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_PICK: begin
        if (stat.any_queued) begin
          cmd.dq_pop = 1'b1;
          state_next = S_EVAL;
        end else begin
          cmd.dq_empty = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_EVAL: begin
        cmd.dq_eval = 1'b1;
        state_next  = stat.keep ? S_DONE : S_PICK;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/pfq_dpath.sv
// Datapath of the frame queue: descriptor memory, ring pointers, totals,
// discard test and result register. Depends on pfq_pkg.
module pfq_dpath #(
  parameter int ENTRIES_PER_PRIO = pfq_pkg::EntriesPerPrio
) (
  input  logic           clk,
  input  logic           rst,
  input  pfq_pkg::req_t  req,
  input  logic           cfg_valid,
  input  logic [0:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  pfq_pkg::cmd_t  cmd,
  output pfq_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pfq_pkg::rsp_t  rsp
);

  localparam int E     = ENTRIES_PER_PRIO;
  localparam int Slots = pfq_pkg::PrioLevels * E;
  localparam int PW    = $clog2(E);
  localparam int CW    = $clog2(E + 1);
  localparam int AW    = $clog2(Slots);
  localparam int FW    = $clog2(Slots + 1);
  localparam int DW    = 99;

  logic [DW-1:0] mem [Slots];
  logic [DW-1:0] rdata;

  pfq_pkg::req_t req_q;
  pfq_pkg::rsp_t res;
  logic [15:0]   hyst;
  logic [15:0]   forced;
  logic [PW-1:0] head  [pfq_pkg::PrioLevels];
  logic [CW-1:0] count [pfq_pkg::PrioLevels];
  logic [FW-1:0] tot_f;
  logic [18:0]   tot_o;
  logic [31:0]   avg;
  logic [33:0]   now2;
  logic [7:0]    frames;
  logic [23:0]   octets;
  logic [1:0]    cur_prio;

  function automatic logic [AW-1:0] base_of(input logic [1:0] p);
    logic [AW-1:0] b;
    case (p)
      pfq_pkg::PRIO_SIG:   b = AW'(E);
      pfq_pkg::PRIO_OTHER: b = AW'(2 * E);
      default:             b = '0;
    endcase
    return b;
  endfunction

  // enqueue / prepend
  logic          is_enq;
  logic [1:0]    sel_prio;
  logic [1:0]    ps;
  logic          reject;
  logic [15:0]   delay;
  logic [32:0]   exp_sum;
  logic [31:0]   enq_exp;
  logic [CW:0]   tail_sum;
  logic [PW-1:0] tail_pos;
  logic [PW-1:0] pre_head;
  logic [PW-1:0] wr_pos;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_recv;
  logic [31:0]   wr_exp;
  pfq_pkg::rsp_t exec_res;

  always_comb begin
    is_enq   = (req_q.opcode == pfq_pkg::OP_ENQ);
    sel_prio = is_enq ? pfq_pkg::sapi_prio(req_q.first_octet) : req_q.put_back_prio;
    ps       = (sel_prio == pfq_pkg::PRIO_NONE) ? pfq_pkg::PRIO_MGMT : sel_prio;
    reject   = (sel_prio == pfq_pkg::PRIO_NONE) || (count[ps] == CW'(E));
    delay    = (forced != 16'd0) ? forced : req_q.lifetime_csec;
    exp_sum  = {1'b0, req_q.now_ms} + 33'(delay) * 33'd10;
    if (delay == pfq_pkg::LIFE_INFINITE) begin
      enq_exp = '0;
    end else if (exp_sum[32]) begin
      enq_exp = '1;
    end else begin
      enq_exp = exp_sum[31:0];
    end
    tail_sum = (CW+1)'(head[ps]) + (CW+1)'(count[ps]);
    tail_pos = (tail_sum >= (CW+1)'(E)) ? PW'(tail_sum - (CW+1)'(E)) : PW'(tail_sum);
    pre_head = (head[ps] == '0) ? PW'(E - 1) : head[ps] - PW'(1);
    wr_pos   = is_enq ? tail_pos : pre_head;
    wr_addr  = base_of(ps) + AW'(wr_pos);
    wr_recv  = is_enq ? req_q.now_ms : req_q.put_back_recv_ms;
    wr_exp   = is_enq ? enq_exp : req_q.put_back_expire_ms;
  end

  // result of enqueue, prepend and clear
  always_comb begin
    exec_res = '0;
    if (req_q.opcode != pfq_pkg::OP_CLEAR) begin
      if (reject) begin
        exec_res.status = pfq_pkg::ST_REJECT;
      end else begin
        exec_res.status        = pfq_pkg::ST_OK;
        exec_res.frame_prio    = ps;
        exec_res.out_tag       = req_q.frame_tag;
        exec_res.out_length    = req_q.frame_length;
        exec_res.out_recv_ms   = wr_recv;
        exec_res.out_expire_ms = wr_exp;
      end
    end
  end

  // dequeue
  logic [1:0]    pick;
  logic          any_q;
  logic [PW-1:0] head_inc;
  logic [10:0]   r_len;
  logic [7:0]    r_octet;
  logic [31:0]   r_recv;
  logic [31:0]   r_exp;
  logic [31:0]   dly;
  logic [32:0]   avg_sum;
  logic          exp_now;
  logic          exp_now2;
  logic          keep;
  logic [24:0]   oct_sum;
  pfq_pkg::rsp_t eval_res;
  pfq_pkg::rsp_t empty_res;
  pfq_pkg::rsp_t out_word;

  always_comb begin
    any_q = 1'b1;
    if (count[0] != '0) begin
      pick = pfq_pkg::PRIO_MGMT;
    end else if (count[1] != '0) begin
      pick = pfq_pkg::PRIO_SIG;
    end else if (count[2] != '0) begin
      pick = pfq_pkg::PRIO_OTHER;
    end else begin
      pick  = pfq_pkg::PRIO_MGMT;
      any_q = 1'b0;
    end
    head_inc = (head[pick] == PW'(E - 1)) ? '0 : head[pick] + PW'(1);
    r_len    = rdata[26:16];
    r_octet  = rdata[34:27];
    r_recv   = rdata[66:35];
    r_exp    = rdata[98:67];
    dly      = (req_q.now_ms >= r_recv) ? req_q.now_ms - r_recv : '0;
    avg_sum  = {1'b0, avg} + {1'b0, dly};
    exp_now  = (r_exp != '0) && (req_q.now_ms > r_exp);
    exp_now2 = (r_exp != '0) && (now2 > {2'b00, r_exp});
    keep     = !exp_now2 ||
               (!exp_now && (frames == '0 || !pfq_pkg::can_discard(r_len, r_octet)));
    oct_sum  = {1'b0, octets} + 25'(r_len);
  end

  always_comb begin
    eval_res                = '0;
    eval_res.status         = pfq_pkg::ST_OK;
    eval_res.frame_prio     = cur_prio;
    eval_res.out_tag        = rdata[15:0];
    eval_res.out_length     = r_len;
    eval_res.out_recv_ms    = r_recv;
    eval_res.out_expire_ms  = r_exp;
    eval_res.dropped_frames = frames;
    eval_res.dropped_octets = octets;
    empty_res                = '0;
    empty_res.status         = pfq_pkg::ST_EMPTY;
    empty_res.dropped_frames = frames;
    empty_res.dropped_octets = octets;
    out_word               = res;
    out_word.queued_frames = 8'(tot_f);
    out_word.queued_octets = tot_o;
    out_word.avg_delay_ms  = avg;
  end

  assign stat.is_deq     = (req_q.opcode == pfq_pkg::OP_DEQ);
  assign stat.any_queued = any_q;
  assign stat.keep       = keep;
  assign stat.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.exec && req_q.opcode != pfq_pkg::OP_CLEAR && !reject) begin
      mem[wr_addr] <= {wr_exp, wr_recv, req_q.first_octet, req_q.frame_length,
                       req_q.frame_tag};
    end
    if (cmd.dq_pop) begin
      rdata <= mem[base_of(pick) + AW'(head[pick])];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst   <= '0;
      forced <= '0;
      tot_f  <= '0;
      tot_o  <= '0;
      avg    <= '0;
      for (int i = 0; i < pfq_pkg::PrioLevels; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pfq_pkg::REG_HYST:   hyst   <= cfg_data;
          pfq_pkg::REG_FORCED: forced <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        res <= exec_res;
        if (req_q.opcode == pfq_pkg::OP_CLEAR) begin
          for (int i = 0; i < pfq_pkg::PrioLevels; i++) begin
            head[i]  <= '0;
            count[i] <= '0;
          end
          tot_f <= '0;
          tot_o <= '0;
        end else if (!reject) begin
          if (!is_enq) begin
            head[ps] <= pre_head;
          end
          count[ps] <= count[ps] + CW'(1);
          tot_f     <= tot_f + FW'(1);
          tot_o     <= tot_o + 19'(req_q.frame_length);
        end
      end
      if (cmd.dq_init) begin
        now2   <= 34'(req_q.now_ms) + 34'(hyst) * 34'd10;
        frames <= '0;
        octets <= '0;
        res    <= '0;
      end
      if (cmd.dq_pop) begin
        head[pick]  <= head_inc;
        count[pick] <= count[pick] - CW'(1);
        cur_prio    <= pick;
      end
      if (cmd.dq_empty) begin
        res <= empty_res;
      end
      if (cmd.dq_eval) begin
        tot_f <= tot_f - FW'(1);
        tot_o <= tot_o - 19'(r_len);
        avg   <= avg_sum[32:1];
        if (keep) begin
          res <= eval_res;
        end else begin
          if (frames != pfq_pkg::FRAMES_MAX) begin
            frames <= frames + 8'd1;
          end
          octets <= oct_sum[24] ? pfq_pkg::OCTETS_MAX : oct_sum[23:0];
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp <= out_word;
    end
  end

endmodule

### bench/priority_frame_queue_lifetime_discard_test.sv
// Testbench of the strict-priority frame queue with lifetime discard.
// Depends on pfq_pkg and priority_frame_queue_lifetime_discard; predicts every result word.
module priority_frame_queue_lifetime_discard_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPRIO = pfq_pkg::PrioLevels;
  localparam int DEPTH = pfq_pkg::EntriesPerPrio;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [15:0] tag;
    logic [10:0] len;
    logic [7:0]  octet;
    logic [31:0] recv;
    logic [31:0] expiry;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  pfq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  pfq_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = pfq_pkg::REG_HYST;
  logic [15:0] cfg_data = '0;

  priority_frame_queue_lifetime_discard DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted queue contents: one model FIFO per priority.
  frame_t fifo_q[NPRIO][$];
  int unsigned held_frames;
  int unsigned held_octets;
  logic [31:0] mean_delay;
  logic [15:0] hyst_csec;
  logic [15:0] forced_csec;

  pfq_pkg::rsp_t pending_words[$];
  int mismatches = 0;
  longint cycles = 0;
  bit stall_free = 1'b0;
  bit sender_busy_free = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [1:0] class_of(logic [7:0] octet);
    case (octet[3:0])
      4'd1: return pfq_pkg::PRIO_MGMT;
      4'd2, 4'd7, 4'd8: return pfq_pkg::PRIO_SIG;
      default: return pfq_pkg::PRIO_OTHER;
    endcase
  endfunction

  function automatic bit aged_out(logic [32:0] t, logic [31:0] expiry);
    return expiry != 0 && t > {1'b0, expiry};
  endfunction

  function automatic bit droppable(logic [10:0] len, logic [7:0] octet);
    return len > 11'd60 && octet[3:0] != 4'd1 && octet[7:5] == 3'b110;
  endfunction

  // Advance the predicted state by one command word; return its result word.
  function automatic pfq_pkg::rsp_t predict_word(pfq_pkg::req_t r);
    pfq_pkg::rsp_t w;
    frame_t f;
    logic [1:0] p;
    logic [15:0] life;
    logic [33:0] sum;
    logic [32:0] late;
    logic [31:0] d;
    int unsigned nf, no;
    bit found;
    w = '0;
    case (r.opcode)
      pfq_pkg::OP_ENQ, pfq_pkg::OP_PREP: begin
        f.tag = r.frame_tag;
        f.len = r.frame_length;
        f.octet = r.first_octet;
        if (r.opcode == pfq_pkg::OP_ENQ) begin
          p = class_of(r.first_octet);
          life = (forced_csec != 0) ? forced_csec : r.lifetime_csec;
          f.recv = r.now_ms;
          if (life == pfq_pkg::LIFE_INFINITE) f.expiry = '0;
          else begin
            sum = r.now_ms + life * 34'd10;
            f.expiry = sum > 34'hffffffff ? 32'hffffffff : sum[31:0];
          end
        end else begin
          p = r.put_back_prio;
          f.recv = r.put_back_recv_ms;
          f.expiry = r.put_back_expire_ms;
        end
        if (p == pfq_pkg::PRIO_NONE || fifo_q[p].size() >= DEPTH) w.status = pfq_pkg::ST_REJECT;
        else begin
          if (r.opcode == pfq_pkg::OP_ENQ) fifo_q[p].push_back(f);
          else fifo_q[p].push_front(f);
          held_frames++;
          held_octets += f.len;
          w.status = pfq_pkg::ST_OK;
          w.frame_prio = p;
          w.out_tag = f.tag;
          w.out_length = f.len;
          w.out_recv_ms = f.recv;
          w.out_expire_ms = f.expiry;
        end
      end
      pfq_pkg::OP_CLEAR: begin
        for (int i = 0; i < NPRIO; i++) fifo_q[i].delete();
        held_frames = 0;
        held_octets = 0;
        w.status = pfq_pkg::ST_OK;
      end
      default: begin
        late = r.now_ms + hyst_csec * 33'd10;
        nf = 0;
        no = 0;
        found = 0;
        forever begin
          p = pfq_pkg::PRIO_NONE;
          for (int i = NPRIO - 1; i >= 0; i--) if (fifo_q[i].size() != 0) p = 2'(i);
          if (p == pfq_pkg::PRIO_NONE) break;
          f = fifo_q[p].pop_front();
          held_frames--;
          held_octets -= f.len;
          d = (r.now_ms >= f.recv) ? r.now_ms - f.recv : '0;
          mean_delay = 32'(({1'b0, mean_delay} + {1'b0, d}) >> 1);
          if (!aged_out(late, f.expiry) || (!aged_out({1'b0, r.now_ms}, f.expiry) &&
              (nf == 0 || !droppable(f.len, f.octet)))) begin
            found = 1;
            w.frame_prio = p;
            w.out_tag = f.tag;
            w.out_length = f.len;
            w.out_recv_ms = f.recv;
            w.out_expire_ms = f.expiry;
            break;
          end
          if (nf < 255) nf++;
          no = (no + f.len > 24'hffffff) ? 24'hffffff : no + f.len;
        end
        w.status = found ? pfq_pkg::ST_OK : pfq_pkg::ST_EMPTY;
        w.dropped_frames = 8'(nf);
        w.dropped_octets = 24'(no);
      end
    endcase
    w.queued_frames = 8'(held_frames);
    w.queued_octets = 19'(held_octets);
    w.avg_delay_ms = mean_delay;
    return w;
  endfunction

  // Drive rsp_ready with random stalls, except during the long clean stretch.
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= stall_free || ($urandom_range(99) >= 20);
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    pfq_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", rsp);
      end else begin
        want = pending_words.pop_front();
        if (rsp !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, rsp);
        end
      end
    end
  end

  // Send one command word; predict its result at acceptance.
  task automatic send_word(pfq_pkg::req_t r);
    while (!sender_busy_free && $urandom_range(99) < 20) @(posedge clk);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_words.push_back(predict_word(r));
    req_valid <= 1'b0;
    // the block is busy right after an accept; let valid drop before the next word
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == pfq_pkg::REG_HYST) hyst_csec = val;
    else forced_csec = val;
  endtask

  function automatic pfq_pkg::req_t make_word(logic [1:0] op, logic [31:0] now);
    pfq_pkg::req_t r;
    r.opcode = op;
    r.now_ms = now;
    r.frame_tag = 16'($urandom);
    r.frame_length = 11'($urandom_range(2047));
    r.first_octet = 8'($urandom);
    r.lifetime_csec = 16'($urandom);
    r.put_back_prio = 2'($urandom_range(3));
    r.put_back_recv_ms = $urandom;
    r.put_back_expire_ms = $urandom;
    return r;
  endfunction

  // Corners: field extremes, every command, saturation, reject, empty dequeue.
  task automatic test_directed();
    pfq_pkg::req_t r;
    send_word(make_word(pfq_pkg::OP_DEQ, '0));       // dequeue on empty
    r = make_word(pfq_pkg::OP_ENQ, 32'hffffff00);
    r.lifetime_csec = 16'hfffe;                      // expiry saturates
    r.first_octet = 8'hff;
    r.frame_length = 11'h7ff;
    r.frame_tag = 16'hffff;
    send_word(r);
    r = make_word(pfq_pkg::OP_ENQ, '0);
    r.lifetime_csec = pfq_pkg::LIFE_INFINITE;
    r.first_octet = 8'h01;
    r.frame_length = '0;
    r.frame_tag = '0;
    send_word(r);
    r = make_word(pfq_pkg::OP_ENQ, 32'd100);
    r.lifetime_csec = '0;
    r.first_octet = 8'hc2;
    send_word(r);
    r = make_word(pfq_pkg::OP_PREP, 32'd5);
    r.put_back_prio = pfq_pkg::PRIO_NONE;            // bad put-back priority
    send_word(r);
    r = make_word(pfq_pkg::OP_PREP, 32'd5);
    r.put_back_prio = pfq_pkg::PRIO_OTHER;
    r.put_back_expire_ms = '0;
    r.put_back_recv_ms = 32'hffffffff;               // recv after now
    send_word(r);
    for (int i = 0; i < 4; i++) send_word(make_word(pfq_pkg::OP_DEQ, 32'hffffffff));
    send_word(make_word(pfq_pkg::OP_CLEAR, '0));
    // Fill one ring past full to hit the reject path.
    for (int i = 0; i < DEPTH + 2; i++) begin
      r = make_word(pfq_pkg::OP_ENQ, 32'(i));
      r.first_octet = 8'h07;
      send_word(r);
    end
    send_word(make_word(pfq_pkg::OP_CLEAR, '0));
  endtask

  // Hysteresis: short-lived frames, mostly long UI ones, dequeued near their expiry.
  task automatic test_hysteresis(int rounds);
    pfq_pkg::req_t r;
    logic [31:0] base;
    for (int k = 0; k < rounds; k++) begin
      base = $urandom_range(1000000);
      for (int i = 0; i < $urandom_range(2, 8); i++) begin
        r = make_word(pfq_pkg::OP_ENQ, base + 32'(i));
        r.lifetime_csec = 16'($urandom_range(0, 30));
        r.first_octet = ($urandom_range(3) != 0) ? {3'b110, 1'b0, 4'd3} : r.first_octet;
        r.frame_length = ($urandom_range(3) != 0) ? 11'($urandom_range(61, 2047)) :
                                                    11'($urandom_range(60));
        send_word(r);
      end
      for (int i = 0; i < 3; i++)
        send_word(make_word(pfq_pkg::OP_DEQ, base + $urandom_range(0, 400)));
    end
  endtask

  task automatic test_random(int count);
    pfq_pkg::req_t r;
    logic [31:0] t;
    int pick;
    t = $urandom_range(1000);
    for (int n = 0; n < count; n++) begin
      t = t + $urandom_range(0, 300);
      pick = $urandom_range(99);
      if (pick < 45) begin
        r = make_word(pfq_pkg::OP_ENQ, t);
        if ($urandom_range(3) == 0) r.lifetime_csec = 16'($urandom_range(0, 50));
        else if ($urandom_range(9) == 0) r.lifetime_csec = pfq_pkg::LIFE_INFINITE;
      end else if (pick < 85) r = make_word(pfq_pkg::OP_DEQ, t);
      else if (pick < 97) begin
        r = make_word(pfq_pkg::OP_PREP, t);
        r.put_back_recv_ms = t - $urandom_range(0, 500);
        if ($urandom_range(1)) r.put_back_expire_ms = t + $urandom_range(0, 2000);
      end else r = make_word(pfq_pkg::OP_CLEAR, t);
      send_word(r);
    end
  endtask

  initial begin
    held_frames = 0;
    held_octets = 0;
    mean_delay = '0;
    hyst_csec = '0;
    forced_csec = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_reg(pfq_pkg::REG_HYST, 16'd20);
    test_hysteresis(15);
    write_reg(pfq_pkg::REG_FORCED, 16'd10);
    test_random(150);
    write_reg(pfq_pkg::REG_FORCED, 16'hffff);
    write_reg(pfq_pkg::REG_HYST, 16'hffff);
    test_random(100);
    write_reg(pfq_pkg::REG_FORCED, 16'd0);
    write_reg(pfq_pkg::REG_HYST, 16'd0);
    drain();                                         // hold off until all results are in
    stall_free = 1'b1;
    sender_busy_free = 1'b1;
    test_random(200);
    stall_free = 1'b0;
    sender_busy_free = 1'b0;
    write_reg(pfq_pkg::REG_HYST, 16'd5);
    test_hysteresis(15);
    test_random(450);
    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### filelist.f
rtl/core/pfq_pkg.sv
rtl/core/pfq_ctrl.sv
rtl/core/pfq_dpath.sv
rtl/core/priority_frame_queue_lifetime_discard.sv
bench/priority_frame_queue_lifetime_discard_test.sv
